>>> src/obo_pkg.sv
// Shared types, widths and table-building functions for the oriented box overlap test.
`timescale 1ns / 1ps

package obo_pkg;

    // Corner coordinates in units of 2^-15: center times 2^15 plus a rotated extent.
    localparam int CORNER_W = 50;
    // Rotated half-extent products, 31-bit unsigned extent times Q1.15 sine.
    localparam int PROD_W   = 48;
    // Projection of a corner on an axis, exact.
    localparam int DOT_W    = 67;
    // Q1.15 sine and cosine values.
    localparam int TRIG_W   = 16;

    // Quarter turn in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // The series terms are divided by small constants through rounded-up reciprocals.
    // With a 49-bit shift the quotient is exact for every dividend below 2^40.
    localparam int RECIP_SHIFT = 49;

    // Reciprocals of (2n)(2n+1) for n from 1 to 8.
    localparam logic [0:7][63:0] SIN_RECIP = '{
        ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6,
        ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20,
        ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42,
        ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72,
        ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
        ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
        ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210,
        ((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272
    };

    // Reciprocals of (2n-1)(2n) for n from 1 to 8.
    localparam logic [0:7][63:0] COS_RECIP = '{
        ((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2,
        ((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12,
        ((64'd1 << RECIP_SHIFT) + 64'd29) / 64'd30,
        ((64'd1 << RECIP_SHIFT) + 64'd55) / 64'd56,
        ((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90,
        ((64'd1 << RECIP_SHIFT) + 64'd131) / 64'd132,
        ((64'd1 << RECIP_SHIFT) + 64'd181) / 64'd182,
        ((64'd1 << RECIP_SHIFT) + 64'd239) / 64'd240
    };

    typedef logic signed [CORNER_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [DOT_W-1:0]    dot_t;
    typedef logic signed [TRIG_W-1:0]   trig_t;

    // Floor of x over a small constant, given that constant's reciprocal.
    function automatic logic [63:0] div_by_recip(input logic [63:0] x,
                                                 input logic [63:0] recip);
        logic [127:0] prod;
        prod = 128'(x) * 128'(recip);
        return prod[RECIP_SHIFT +: 64];
    endfunction

    // Q30 sine on the first quadrant by a Taylor series, used only at elaboration.
    function automatic logic [63:0] sin_q30(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] term;
        longint      sum;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int n = 1; n <= 8; n++) begin
            term = div_by_recip((term * a2) >> 30, SIN_RECIP[3'(n - 1)]);
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return 64'(sum);
    endfunction

    // Q30 cosine on the first quadrant by a Taylor series, used only at elaboration.
    function automatic logic [63:0] cos_q30(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] term;
        longint      sum;
        a2   = (a * a) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(1) << 30;
        for (int n = 1; n <= 8; n++) begin
            term = div_by_recip((term * a2) >> 30, COS_RECIP[3'(n - 1)]);
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return 64'(sum);
    endfunction

endpackage

>>> src/obo_sine_rom.sv
// Sine lookup table over a full turn with a registered read port.
`timescale 1ns / 1ps

module obo_sine_rom #(
    parameter int ANGLE_BITS = 16,
    parameter int ENTRIES    = 1024
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output obo_pkg::trig_t        value
);
    import obo_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MUL_W = ANGLE_BITS + $clog2(ENTRIES + 1);

    trig_t              tab [ENTRIES];
    trig_t              value_reg;
    logic [MUL_W-1:0]   scaled;
    logic [IDX_W-1:0]   idx;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_tab
        localparam logic [63:0] Q   = 64'(4 * k) / ENTRIES;
        localparam logic [63:0] R   = 64'(4 * k) % ENTRIES;
        localparam logic [63:0] A   = (HALF_PI_Q30 * R) / ENTRIES;
        localparam logic [63:0] V   = Q[0] ? cos_q30(A) : sin_q30(A);
        localparam logic [63:0] MAG = (64'd32767 * V + (64'd1 << 29)) >> 30;
        localparam trig_t       POS = trig_t'(MAG);
        assign tab[k] = (Q >= 64'd2) ? -POS : POS;
    end

    // The entry index is floor(angle * ENTRIES / full turn).
    assign scaled = MUL_W'(angle) * MUL_W'(ENTRIES);
    assign idx    = IDX_W'(scaled >> ANGLE_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= tab[idx];
        end
    end

    assign value = value_reg;

endmodule

>>> src/obo_box_geom.sv
// Corner and edge-normal generation for one rotated box, two pipeline stages.
`timescale 1ns / 1ps

module obo_box_geom (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic [30:0]           half_w,
    input  logic [30:0]           half_h,
    input  obo_pkg::trig_t        sin_val,
    input  obo_pkg::trig_t        cos_val,
    output obo_pkg::coord_t       corner_x [4],
    output obo_pkg::coord_t       corner_y [4],
    output obo_pkg::trig_t        axis_x [2],
    output obo_pkg::trig_t        axis_y [2]
);
    import obo_pkg::*;

    logic signed [31:0] hw_s;
    logic signed [31:0] hh_s;

    prod_t  hxc_reg, hys_reg, hxs_reg, hyc_reg;
    coord_t px_reg, py_reg;
    trig_t  s_reg, c_reg;
    logic   hx_nz_reg, hy_nz_reg;

    coord_t a_rot, b_rot, a2_rot, b2_rot;
    coord_t cx_reg [4];
    coord_t cy_reg [4];
    trig_t  ux_reg [2];
    trig_t  uy_reg [2];

    assign hw_s = $signed({1'b0, half_w});
    assign hh_s = $signed({1'b0, half_h});

    // Stage: rotate the half extents.
    always_ff @(posedge aclk) begin
        if (en) begin
            hxc_reg   <= prod_t'(hw_s) * prod_t'(cos_val);
            hys_reg   <= prod_t'(hh_s) * prod_t'(sin_val);
            hxs_reg   <= prod_t'(hw_s) * prod_t'(sin_val);
            hyc_reg   <= prod_t'(hh_s) * prod_t'(cos_val);
            px_reg    <= coord_t'(pos_x) <<< 15;
            py_reg    <= coord_t'(pos_y) <<< 15;
            s_reg     <= sin_val;
            c_reg     <= cos_val;
            hx_nz_reg <= |half_w;
            hy_nz_reg <= |half_h;
        end
    end

    assign a_rot  = coord_t'(hxc_reg) - coord_t'(hys_reg);
    assign b_rot  = coord_t'(hxs_reg) + coord_t'(hyc_reg);
    assign a2_rot = coord_t'(hxc_reg) + coord_t'(hys_reg);
    assign b2_rot = coord_t'(hyc_reg) - coord_t'(hxs_reg);

    // Stage: corners in the order left bottom, right top, left top, right bottom.
    // A zero half extent gives a zero normal, which never separates.
    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= px_reg - a_rot;
            cy_reg[0] <= py_reg - b_rot;
            cx_reg[1] <= px_reg + a_rot;
            cy_reg[1] <= py_reg + b_rot;
            cx_reg[2] <= px_reg - a2_rot;
            cy_reg[2] <= py_reg + b2_rot;
            cx_reg[3] <= px_reg + a2_rot;
            cy_reg[3] <= py_reg - b2_rot;
            ux_reg[0] <= hy_nz_reg ? c_reg : '0;
            uy_reg[0] <= hy_nz_reg ? s_reg : '0;
            ux_reg[1] <= hx_nz_reg ? -s_reg : '0;
            uy_reg[1] <= hx_nz_reg ? c_reg : '0;
        end
    end

    assign corner_x = cx_reg;
    assign corner_y = cy_reg;
    assign axis_x   = ux_reg;
    assign axis_y   = uy_reg;

endmodule

>>> src/obo_axis_test.sv
// Projection interval overlap on one axis, five pipeline stages.
`timescale 1ns / 1ps

module obo_axis_test (
    input  logic             aclk,
    input  logic             en,
    input  obo_pkg::coord_t  first_x [4],
    input  obo_pkg::coord_t  first_y [4],
    input  obo_pkg::coord_t  second_x [4],
    input  obo_pkg::coord_t  second_y [4],
    input  obo_pkg::trig_t   axis_x,
    input  obo_pkg::trig_t   axis_y,
    output logic             hit
);
    import obo_pkg::*;

    dot_t p1x_reg [4];
    dot_t p1y_reg [4];
    dot_t p2x_reg [4];
    dot_t p2y_reg [4];
    dot_t d1_reg [4];
    dot_t d2_reg [4];
    dot_t lo1_reg [2];
    dot_t hi1_reg [2];
    dot_t lo2_reg [2];
    dot_t hi2_reg [2];
    dot_t a0_reg, a3_reg, b0_reg, b3_reg;
    logic hit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                p1x_reg[i] <= dot_t'(first_x[i]) * dot_t'(axis_x);
                p1y_reg[i] <= dot_t'(first_y[i]) * dot_t'(axis_y);
                p2x_reg[i] <= dot_t'(second_x[i]) * dot_t'(axis_x);
                p2y_reg[i] <= dot_t'(second_y[i]) * dot_t'(axis_y);
                d1_reg[i]  <= p1x_reg[i] + p1y_reg[i];
                d2_reg[i]  <= p2x_reg[i] + p2y_reg[i];
            end
            for (int j = 0; j < 2; j++) begin
                lo1_reg[j] <= (d1_reg[2*j] <= d1_reg[2*j+1]) ? d1_reg[2*j] : d1_reg[2*j+1];
                hi1_reg[j] <= (d1_reg[2*j] <= d1_reg[2*j+1]) ? d1_reg[2*j+1] : d1_reg[2*j];
                lo2_reg[j] <= (d2_reg[2*j] <= d2_reg[2*j+1]) ? d2_reg[2*j] : d2_reg[2*j+1];
                hi2_reg[j] <= (d2_reg[2*j] <= d2_reg[2*j+1]) ? d2_reg[2*j+1] : d2_reg[2*j];
            end
            a0_reg  <= (lo1_reg[0] <= lo1_reg[1]) ? lo1_reg[0] : lo1_reg[1];
            a3_reg  <= (hi1_reg[0] >= hi1_reg[1]) ? hi1_reg[0] : hi1_reg[1];
            b0_reg  <= (lo2_reg[0] <= lo2_reg[1]) ? lo2_reg[0] : lo2_reg[1];
            b3_reg  <= (hi2_reg[0] >= hi2_reg[1]) ? hi2_reg[0] : hi2_reg[1];
            // Touching intervals count as overlapping.
            hit_reg <= (a0_reg <= b0_reg) ? (b0_reg <= a3_reg) : (a0_reg <= b3_reg);
        end
    end

    assign hit = hit_reg;

endmodule

>>> src/oriented_box_overlap_test.sv
// Top level of the two-dimensional oriented box overlap test.
`timescale 1ns / 1ps

// Each request carries two rotated boxes (center, half extents, binary angle) and yields
// one result: broad_pass is set when both center gaps lie within 1.2 times the sum of the
// boxes' larger half extents, and colliding is set when broad_pass holds and none of the
// four axes normal to the box edges separates the boxes. The pipeline takes one request
// every cycle when the result side does not stall. Its stages: one for the sine table
// reads and the center differences, two for the corner geometry, five for the axis
// projections and their interval compares, and one output register. All arithmetic is
// exact, so results do not depend on rounding. A stall at the result side holds the
// whole pipeline, and s_tready then falls until the waiting result is taken.
module oriented_box_overlap_test #(
    parameter int ANGLE_BITS         = 16,
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_pos_x, first_pos_y, first_half_width, first_half_height, first_angle,
    // second_pos_x, second_pos_y, second_half_width, second_half_height, second_angle,
    // then four zero bits.
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // colliding, broad_pass, then six zero bits.
    output logic [7:0]   m_tdata
);
    import obo_pkg::*;

    localparam int LAT = 9;

    logic en;

    logic signed [31:0]    f_px, f_py, g_px, g_py;
    logic [30:0]           f_hw, f_hh, g_hw, g_hh;
    logic [ANGLE_BITS-1:0] f_ang, g_ang, f_cang, g_cang;

    logic signed [31:0] f_px_reg, f_py_reg, g_px_reg, g_py_reg;
    logic [30:0]        f_hw_reg, f_hh_reg, g_hw_reg, g_hh_reg;
    logic [32:0]        dx_reg, dy_reg;
    logic [31:0]        msum_reg;
    logic signed [32:0] dx_raw, dy_raw;
    logic [30:0]        f_max, g_max;

    trig_t f_sin, f_cos, g_sin, g_cos;

    coord_t f_cx [4];
    coord_t f_cy [4];
    coord_t g_cx [4];
    coord_t g_cy [4];
    trig_t  f_ux [2];
    trig_t  f_uy [2];
    trig_t  g_ux [2];
    trig_t  g_uy [2];
    logic [3:0] axis_hit;

    logic [LAT-2:0] v_reg;
    logic [LAT-2:0] v_next;
    logic           broad_reg;
    logic [5:0]     broad_pipe_reg;
    logic           m_valid_reg;
    logic           colliding_reg;
    logic           broad_pass_reg;

    // The output register parts the two sides; everything moves together.
    assign en       = ~m_valid_reg | m_tready;
    assign s_tready = en;

    assign f_px  = $signed(s_tdata[31:0]);
    assign f_py  = $signed(s_tdata[63:32]);
    assign f_hw  = s_tdata[94:64];
    assign f_hh  = s_tdata[125:95];
    assign f_ang = s_tdata[126 +: ANGLE_BITS];
    assign g_px  = $signed(s_tdata[173:142]);
    assign g_py  = $signed(s_tdata[205:174]);
    assign g_hw  = s_tdata[236:206];
    assign g_hh  = s_tdata[267:237];
    assign g_ang = s_tdata[268 +: ANGLE_BITS];

    // Cosine is the sine a quarter turn ahead; the sum wraps at a full turn.
    assign f_cang = f_ang + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    assign g_cang = g_ang + ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    obo_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_f_sin (
        .aclk(aclk), .en(en), .angle(f_ang), .value(f_sin)
    );
    obo_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_f_cos (
        .aclk(aclk), .en(en), .angle(f_cang), .value(f_cos)
    );
    obo_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_g_sin (
        .aclk(aclk), .en(en), .angle(g_ang), .value(g_sin)
    );
    obo_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_g_cos (
        .aclk(aclk), .en(en), .angle(g_cang), .value(g_cos)
    );

    // Broad phase: center gaps against the enlarged square bounds.
    assign dx_raw = 33'(f_px) - 33'(g_px);
    assign dy_raw = 33'(f_py) - 33'(g_py);
    assign f_max  = (f_hh > f_hw) ? f_hh : f_hw;
    assign g_max  = (g_hh > g_hw) ? g_hh : g_hw;

    always_ff @(posedge aclk) begin
        if (en) begin
            f_px_reg <= f_px;
            f_py_reg <= f_py;
            f_hw_reg <= f_hw;
            f_hh_reg <= f_hh;
            g_px_reg <= g_px;
            g_py_reg <= g_py;
            g_hw_reg <= g_hw;
            g_hh_reg <= g_hh;
            dx_reg   <= dx_raw[32] ? 33'(-dx_raw) : 33'(dx_raw);
            dy_reg   <= dy_raw[32] ? 33'(-dy_raw) : 33'(dy_raw);
            msum_reg <= 32'(f_max) + 32'(g_max);
            // The gap |d| - 1.2 * (m1 + m2) is not positive exactly when 5|d| <= 6(m1 + m2).
            broad_reg <= (({3'b0, dx_reg} * 36'd5) <= ({4'b0, msum_reg} * 36'd6))
                      && (({3'b0, dy_reg} * 36'd5) <= ({4'b0, msum_reg} * 36'd6));
            broad_pipe_reg <= {broad_pipe_reg[4:0], broad_reg};
            colliding_reg  <= broad_pipe_reg[5] & (&axis_hit);
            broad_pass_reg <= broad_pipe_reg[5];
        end
    end

    obo_box_geom u_f_geom (
        .aclk(aclk), .en(en),
        .pos_x(f_px_reg), .pos_y(f_py_reg), .half_w(f_hw_reg), .half_h(f_hh_reg),
        .sin_val(f_sin), .cos_val(f_cos),
        .corner_x(f_cx), .corner_y(f_cy), .axis_x(f_ux), .axis_y(f_uy)
    );
    obo_box_geom u_g_geom (
        .aclk(aclk), .en(en),
        .pos_x(g_px_reg), .pos_y(g_py_reg), .half_w(g_hw_reg), .half_h(g_hh_reg),
        .sin_val(g_sin), .cos_val(g_cos),
        .corner_x(g_cx), .corner_y(g_cy), .axis_x(g_ux), .axis_y(g_uy)
    );

    // Axes zero and one are the first box's normals, two and three the second box's.
    for (genvar i = 0; i < 4; i++) begin : g_axis
        if (i < 2) begin : g_first
            obo_axis_test u_axis (
                .aclk(aclk), .en(en),
                .first_x(f_cx), .first_y(f_cy), .second_x(g_cx), .second_y(g_cy),
                .axis_x(f_ux[i]), .axis_y(f_uy[i]), .hit(axis_hit[i])
            );
        end else begin : g_second
            obo_axis_test u_axis (
                .aclk(aclk), .en(en),
                .first_x(f_cx), .first_y(f_cy), .second_x(g_cx), .second_y(g_cy),
                .axis_x(g_ux[i-2]), .axis_y(g_uy[i-2]), .hit(axis_hit[i])
            );
        end
    end

    assign v_next = {v_reg[LAT-3:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= v_next;
            m_valid_reg <= v_reg[LAT-2];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, broad_pass_reg, colliding_reg};

`ifndef NO_ASSERTIONS
    a_no_hit_without_broad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> !m_tdata[0])
        else $error("colliding set while broad phase rejected the pair");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while a result waits");

    a_valid_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && v_reg[LAT-2] |=> m_tvalid)
        else $error("finished request did not reach the output");
`endif

endmodule

>>> test/oriented_box_overlap_test_tb.sv
// Self-checking testbench for the oriented box overlap test.
`timescale 1ns / 1ps

// Box pairs go in as requests on the s_ channel, and one result per request comes back
// on the m_ channel. A behavioral model in this file predicts broad_pass and colliding for
// each accepted request, and a queue holds the predictions in order. Both channels idle in
// random bursts, and at one point the receiver holds off long enough to fill the pipeline.
module oriented_box_overlap_test_tb;

    localparam int ANGLE_BITS = 16;
    localparam int TABLE_SIZE = 1024;
    localparam int LATENCY    = 9;
    localparam int N_RANDOM   = 600;
    localparam longint CYCLE_LIMIT = 200000;
    localparam longint HALF_PI_Q30 = 1686629713;

    typedef struct packed {
        logic [15:0] angle;
        logic [30:0] half_h;
        logic [30:0] half_w;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } box_t;

    typedef struct {
        box_t first;
        box_t second;
    } box_pair_t;

    typedef struct {
        bit colliding;
        bit broad_pass;
    } verdict_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    oriented_box_overlap_test #(
        .ANGLE_BITS(ANGLE_BITS),
        .SINE_TABLE_ENTRIES(TABLE_SIZE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    box_pair_t pending_pairs[$];
    verdict_t  expected_verdicts[$];
    longint    sine_q15[TABLE_SIZE];
    int        error_count;
    int        checked_count;
    int        broad_count;
    int        hit_count;
    longint    cycle_count;
    bit        stimulus_done;
    bit        idling_on;
    bit        hold_request;
    int        hold_left;
    bit        offer_taken;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Q30 Taylor series on the first quadrant; odd selects the sine series.
    function automatic longint taylor_q30(longint a, bit odd);
        longint a2;
        longint term;
        longint sum;
        a2   = (a * a) >>> 30;
        term = odd ? a : (longint'(1) << 30);
        sum  = term;
        for (int n = 1; n <= 8; n++) begin
            if (odd) begin
                term = ((term * a2) >>> 30) / ((2 * n) * (2 * n + 1));
            end else begin
                term = ((term * a2) >>> 30) / ((2 * n - 1) * (2 * n));
            end
            sum = (n % 2 == 1) ? sum - term : sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return sum;
    endfunction

    function automatic void build_sine_table();
        longint quadrant;
        longint remain;
        longint arg;
        longint mag;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            quadrant = (4 * k) / TABLE_SIZE;
            remain   = (4 * k) % TABLE_SIZE;
            arg      = (HALF_PI_Q30 * remain) / TABLE_SIZE;
            mag = (32767 * taylor_q30(arg, quadrant % 2 == 0) + (longint'(1) << 29)) >>> 30;
            sine_q15[k] = (quadrant >= 2) ? -mag : mag;
        end
    endfunction

    function automatic longint sine_at(logic [15:0] angle);
        return sine_q15[(int'(angle) * TABLE_SIZE) >> ANGLE_BITS];
    endfunction

    // Corners in units of 2^-15, plus the two box normals (zero when the extent is zero).
    function automatic void box_geometry(box_t b, output longint cx[4], output longint cy[4],
                                         output longint axx[2], output longint axy[2]);
        longint px;
        longint py;
        longint hx;
        longint hy;
        longint s;
        longint c;
        longint u1;
        longint v1;
        longint u2;
        longint v2;
        px = longint'(signed'(b.pos_x)) * 32768;
        py = longint'(signed'(b.pos_y)) * 32768;
        hx = longint'(b.half_w);
        hy = longint'(b.half_h);
        s  = sine_at(b.angle);
        c  = sine_at(b.angle + 16'h4000);
        u1 = hx * c - hy * s;
        v1 = hx * s + hy * c;
        u2 = hx * c + hy * s;
        v2 = hy * c - hx * s;
        cx[0] = px - u1; cy[0] = py - v1;
        cx[1] = px + u1; cy[1] = py + v1;
        cx[2] = px - u2; cy[2] = py + v2;
        cx[3] = px + u2; cy[3] = py - v2;
        axx[0] = (hy != 0) ? c : 0;  axy[0] = (hy != 0) ? s : 0;
        axx[1] = (hx != 0) ? -s : 0; axy[1] = (hx != 0) ? c : 0;
    endfunction

    function automatic verdict_t predict_overlap(box_pair_t p);
        verdict_t  v;
        longint    m1;
        longint    m2;
        longint    dx;
        longint    dy;
        longint    x1[4];
        longint    y1[4];
        longint    x2[4];
        longint    y2[4];
        longint    ax[4];
        longint    ay[4];
        longint    tx[2];
        longint    ty[2];
        logic signed [127:0] proj;
        logic signed [127:0] lo1;
        logic signed [127:0] hi1;
        logic signed [127:0] lo2;
        logic signed [127:0] hi2;
        m1 = longint'(p.first.half_w) > longint'(p.first.half_h) ?
             longint'(p.first.half_w) : longint'(p.first.half_h);
        m2 = longint'(p.second.half_w) > longint'(p.second.half_h) ?
             longint'(p.second.half_w) : longint'(p.second.half_h);
        dx = longint'(signed'(p.first.pos_x)) - longint'(signed'(p.second.pos_x));
        dy = longint'(signed'(p.first.pos_y)) - longint'(signed'(p.second.pos_y));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        v.broad_pass = (5 * dx - 6 * (m1 + m2) <= 0) && (5 * dy - 6 * (m1 + m2) <= 0);
        v.colliding  = v.broad_pass;
        if (!v.broad_pass) begin
            return v;
        end
        box_geometry(p.first, x1, y1, tx, ty);
        ax[0] = tx[0]; ay[0] = ty[0]; ax[1] = tx[1]; ay[1] = ty[1];
        box_geometry(p.second, x2, y2, tx, ty);
        ax[2] = tx[0]; ay[2] = ty[0]; ax[3] = tx[1]; ay[3] = ty[1];
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                proj = 128'(signed'(x1[k])) * ax[i] + 128'(signed'(y1[k])) * ay[i];
                if (k == 0 || proj < lo1) lo1 = proj;
                if (k == 0 || proj > hi1) hi1 = proj;
                proj = 128'(signed'(x2[k])) * ax[i] + 128'(signed'(y2[k])) * ay[i];
                if (k == 0 || proj < lo2) lo2 = proj;
                if (k == 0 || proj > hi2) hi2 = proj;
            end
            if (hi1 < lo2 || hi2 < lo1) begin
                v.colliding = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic logic [287:0] pack_pair(box_pair_t p);
        return {4'b0, p.second, p.first};
    endfunction

    // Appends a pair at the tail of the pending queue.
    function automatic void add_pair(box_pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 checked_count, what, got, want);
        error_count++;
    endtask

    function automatic box_t random_box(int scale);
        box_t b;
        b.pos_x  = $urandom;
        b.pos_y  = $urandom;
        b.half_w = 31'($urandom);
        b.half_h = 31'($urandom);
        b.angle  = 16'($urandom);
        if (scale > 0) begin
            // Keep boxes in a small arena so that most pairs pass the broad phase.
            b.pos_x  = 32'($signed($urandom_range(0, 2 * scale)) - scale);
            b.pos_y  = 32'($signed($urandom_range(0, 2 * scale)) - scale);
            b.half_w = 31'($urandom_range(0, scale));
            b.half_h = 31'($urandom_range(0, scale));
        end
        return b;
    endfunction

    function automatic box_t make_box(logic [31:0] x, logic [31:0] y, logic [30:0] w,
                                      logic [30:0] h, logic [15:0] a);
        box_t b;
        b.pos_x = x; b.pos_y = y; b.half_w = w; b.half_h = h; b.angle = a;
        return b;
    endfunction

    // Stimulus: directed corner cases, then random pairs, mostly close together.
    initial begin
        box_pair_t p;
        int        scale;
        build_sine_table();
        error_count   = 0;
        stimulus_done = 1'b0;
        // Touching and separated axis-aligned boxes, then an overlapping rotated pair.
        p.first = make_box(0, 0, 31'h10000, 31'h10000, 0);
        p.second = make_box(32'h20000, 0, 31'h10000, 31'h10000, 0);
        add_pair(p);
        p.second = make_box(32'h20001, 0, 31'h10000, 31'h10000, 0);
        add_pair(p);
        p.second = make_box(32'h20001, 0, 31'h10000, 31'h10000, 16'h2000);
        add_pair(p);
        // Zero extents, which give zero axes.
        p.first = make_box(0, 0, 0, 0, 16'h1234);
        p.second = make_box(0, 0, 0, 0, 16'hFFFF);
        add_pair(p);
        p.first = make_box(32'h100, 0, 31'h8000, 0, 16'h4000);
        add_pair(p);
        // Extreme positions and extents.
        p.first = make_box(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'hFFFF);
        p.second = make_box(32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
        add_pair(p);
        p.first = make_box(32'h7FFFFFFF, 32'h80000000, 0, 0, 16'h8000);
        p.second = make_box(32'h80000000, 32'h7FFFFFFF, 0, 0, 16'hC000);
        add_pair(p);
        // Broad phase fails on only one axis: on x, then on y.
        p.first = make_box(0, 0, 31'd5, 31'd5, 0);
        p.second = make_box(32'd12, 0, 31'd0, 31'd0, 0);
        add_pair(p);
        p.second = make_box(0, 32'd13, 31'd0, 31'd0, 0);
        add_pair(p);
        // A thin rotated box crossing a corner region.
        for (int a = 0; a < 8; a++) begin
            p.first = make_box(0, 0, 31'h40000, 31'h1000, 16'(a * 16'h2000 + 16'h0FFF));
            p.second = make_box(32'h30000, 32'h30000, 31'h10000, 31'h10000, 16'(a * 16'h1111));
            add_pair(p);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 9))
                0: scale = 0;
                1, 2: scale = $urandom_range(1, 32'h7FFFFFFF);
                default: scale = $urandom_range(16, 32'h80000);
            endcase
            p.first  = random_box(scale);
            p.second = random_box(scale);
            add_pair(p);
        end
        stimulus_done = 1'b1;
    end

    // Reset, and clear the cycle count.
    initial begin
        aresetn     = 1'b0;
        cycle_count = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Idling stops for the final stretch of the run.
    assign idling_on = (pending_pairs.size() > 100);

    // Driver: presents the next pending pair, idling in random bursts. An offer that has
    // not been taken yet stays on the bus unchanged.
    int send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else if (!s_tvalid || offer_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 12) - 1;
                s_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pack_pair(pending_pairs[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // A handshake at the rising edge means the head pair was taken; predict it there.
    always @(posedge aclk) begin
        offer_taken = aresetn && s_tvalid && s_tready;
        if (offer_taken) begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     predict_overlap(pending_pairs[0]));
            void'(pending_pairs.pop_front());
        end
    end

    // The long hold-off: once, after a hundred results, the receiver stops until hold_left runs out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left    <= 0;
            hold_request <= 1'b0;
        end else if (!hold_request && checked_count >= 100) begin
            hold_request <= 1'b1;
            hold_left    <= 200;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    int recv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want.colliding) begin
                    report_mismatch("colliding", m_tdata[0], want.colliding);
                end
                if (m_tdata[1] !== want.broad_pass) begin
                    report_mismatch("broad_pass", m_tdata[1], want.broad_pass);
                end
                if (m_tdata[7:2] !== 6'b0) begin
                    report_mismatch("padding", m_tdata[7:2], 0);
                end
                broad_count += want.broad_pass;
                hit_count   += want.colliding;
            end
            checked_count++;
        end
    end

    // End of run: drain, allow the pipeline latency, then report; or give up at the limit.
    initial begin
        checked_count = 0;
        broad_count   = 0;
        hit_count     = 0;
        wait (aresetn === 1'b1);
        while (!(stimulus_done && pending_pairs.size() == 0 && expected_verdicts.size() == 0)
               && cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_verdicts.size());
            $display("oriented_box_overlap_test_tb: done, errors");
        end else begin
            repeat (4 * LATENCY) @(posedge aclk);
            $display("checked %0d box pairs: %0d passed the broad phase, %0d overlapped",
                     checked_count, broad_count, hit_count);
            if (error_count == 0 && expected_verdicts.size() == 0) begin
                $display("oriented_box_overlap_test_tb: done, clean");
            end else begin
                $display("oriented_box_overlap_test_tb: done, errors");
            end
        end
        $finish;
    end

endmodule
